// File: rtl/core/cmi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_pkg
// Palette codes, palette ROM and shared widths for the colormap interpolator.
// ----------------------------------------------------------------------------
package cmi_pkg;

    localparam int PAL_W     = 3;
    localparam int SEG_W     = 4;
    localparam int ROW_DEPTH = 16;

    localparam logic [PAL_W-1:0] PAL_DIVERGING = 3'd0;
    localparam logic [PAL_W-1:0] PAL_YLORBR    = 3'd1;
    localparam logic [PAL_W-1:0] PAL_BLUES     = 3'd2;
    localparam logic [PAL_W-1:0] PAL_REDS      = 3'd3;
    localparam logic [PAL_W-1:0] PAL_GREENS    = 3'd4;
    localparam logic [PAL_W-1:0] PAL_COUNT     = 3'd5;

    localparam logic [SEG_W-1:0] DIV_LAST = 4'd10;
    localparam logic [SEG_W-1:0] SEQ_LAST = 4'd8;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam logic [23:0] PAL_ROM [5][ROW_DEPTH] = '{
        '{24'h67001f, 24'hb2182b, 24'hd6604d, 24'hf4a582,
          24'hfddbc7, 24'hf7f7f7, 24'hd1e5f0, 24'h92c5de,
          24'h4393c3, 24'h2166ac, 24'h053061, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'hffffe5, 24'hfff7bc, 24'hfee391, 24'hfec44f,
          24'hfe9929, 24'hec7014, 24'hcc4c02, 24'h993404,
          24'h662506, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'hf7fbff, 24'hdeebf7, 24'hc6dbef, 24'h9ecae1,
          24'h6baed6, 24'h4292c6, 24'h2171b5, 24'h08519c,
          24'h08306b, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'hfff5f0, 24'hfee0d2, 24'hfcbba1, 24'hfc9272,
          24'hfb6a4a, 24'hef3b2c, 24'hcb181d, 24'ha50f15,
          24'h67000d, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000},
        '{24'hf7fcf5, 24'he5f5e0, 24'hc7e9c0, 24'ha1d99b,
          24'h74c476, 24'h41ab5d, 24'h238b45, 24'h006d2c,
          24'h00441b, 24'h000000, 24'h000000, 24'h000000,
          24'h000000, 24'h000000, 24'h000000, 24'h000000}
    };

    function automatic rgb_t pal_color(input logic [PAL_W-1:0] pal,
                                       input logic [SEG_W-1:0] idx);
        rgb_t c;
        case (pal)
            PAL_YLORBR: c = rgb_t'(PAL_ROM[1][idx]);
            PAL_BLUES:  c = rgb_t'(PAL_ROM[2][idx]);
            PAL_REDS:   c = rgb_t'(PAL_ROM[3][idx]);
            PAL_GREENS: c = rgb_t'(PAL_ROM[4][idx]);
            default:    c = rgb_t'(PAL_ROM[0][idx]);
        endcase
        return c;
    endfunction

endpackage

// File: rtl/core/colormap_interpolator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_interpolator
// Maps a level in [0,1] to an RGB colour through one of five palettes with
// linear interpolation between palette entries.
//
//   channel   ports                        handshake
//   input     start, busy, level           taken when start && !busy
//   result    done, red, green, blue       one-cycle strobe on done
//   config    cfg_valid, cfg_ready, cfg_data  written when valid && ready
//
// one item per cycle; a result leaves once its item has passed through the queue
// register, the ROM read stage and the blend stage
// the back half drains the queue every cycle, so busy stays low in use
// reset clears the palette register to the diverging palette and empties the
// queue and pipeline
// ----------------------------------------------------------------------------
module colormap_interpolator
    import cmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [FRAC_BITS:0] level,
    output logic               done,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [PAL_W-1:0]   cfg_data
);

    localparam int Q_WIDTH = PAL_W + SEG_W + FRAC_BITS;

    logic                 q_full;
    logic                 push;
    logic [PAL_W-1:0]     f_pal;
    logic [SEG_W-1:0]     f_seg;
    logic [FRAC_BITS-1:0] f_frac;
    logic                 pop;
    logic                 q_not_empty;
    logic [Q_WIDTH-1:0]   q_rdata;

    cmi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .level     (level),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .push      (push),
        .pal       (f_pal),
        .seg       (f_seg),
        .frac      (f_frac)
    );

    cmi_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     ({f_pal, f_seg, f_frac}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    cmi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_not_empty),
        .pop      (pop),
        .pal      (q_rdata[Q_WIDTH-1 -: PAL_W]),
        .seg      (q_rdata[FRAC_BITS +: SEG_W]),
        .frac     (q_rdata[FRAC_BITS-1:0]),
        .done     (done),
        .red      (red),
        .green    (green),
        .blue     (blue)
    );

endmodule

// File: rtl/core/cmi_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_front
// Takes items, holds the palette register and splits level into segment and
// fraction, or picks an end entry.
// ----------------------------------------------------------------------------
module cmi_front
    import cmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [FRAC_BITS:0]   level,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [PAL_W-1:0]     cfg_data,
    input  logic                 q_full,
    output logic                 push,
    output logic [PAL_W-1:0]     pal,
    output logic [SEG_W-1:0]     seg,
    output logic [FRAC_BITS-1:0] frac
);

    localparam int SCALED_W = FRAC_BITS + SEG_W;

    logic [PAL_W-1:0]    palette_select_reg;
    logic [PAL_W-1:0]    palette_select_next;
    logic                is_div;
    logic [SEG_W-1:0]    last_idx;
    logic [SCALED_W-1:0] lvl_ext;
    logic [SCALED_W-1:0] scaled;

    assign cfg_ready = 1'b1;
    assign busy      = q_full;
    assign push      = start && !q_full;

    always_comb
    begin
        palette_select_next = palette_select_reg;
        if (cfg_valid)
        begin
            palette_select_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_select_reg <= PAL_DIVERGING;
        end
        else
        begin
            palette_select_reg <= palette_select_next;
        end
    end

    // codes past the last palette fall back to the diverging one
    always_comb
    begin
        pal      = (palette_select_reg < PAL_COUNT) ? palette_select_reg : PAL_DIVERGING;
        is_div   = (pal == PAL_DIVERGING);
        last_idx = is_div ? DIV_LAST : SEQ_LAST;
        lvl_ext  = SCALED_W'(level[FRAC_BITS-1:0]);
        scaled   = (lvl_ext << 3) + (is_div ? (lvl_ext << 1) : '0);
        if (level[FRAC_BITS])
        begin
            seg  = last_idx;
            frac = '0;
        end
        else
        begin
            seg  = scaled[SCALED_W-1:FRAC_BITS];
            frac = scaled[FRAC_BITS-1:0];
        end
    end

endmodule

// File: rtl/core/cmi_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_queue
// Short register queue between the front and back halves.
// ----------------------------------------------------------------------------
module cmi_queue
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rdata
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/core/cmi_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmi_back
// Reads the two end colours of a segment and blends them, one item a cycle.
// ----------------------------------------------------------------------------
module cmi_back
    import cmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 pop,
    input  logic [PAL_W-1:0]     pal,
    input  logic [SEG_W-1:0]     seg,
    input  logic [FRAC_BITS-1:0] frac,
    output logic                 done,
    output logic [7:0]           red,
    output logic [7:0]           green,
    output logic [7:0]           blue
);

    localparam int SUM_W = FRAC_BITS + 10;

    logic                 lut_valid_reg;
    rgb_t                 lo_reg;
    rgb_t                 hi_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic                 done_reg;
    rgb_t                 color_reg;
    rgb_t                 color_next;

    function automatic logic [7:0] blend(input logic [7:0] a,
                                         input logic [7:0] b,
                                         input logic [FRAC_BITS-1:0] f);
        logic signed [8:0]       diff;
        logic signed [SUM_W-1:0] sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        sum  = $signed(SUM_W'({a, FRAC_BITS'(0)}))
             + SUM_W'(diff) * SUM_W'($signed({1'b0, f}))
             + $signed(SUM_W'({1'b1, (FRAC_BITS - 1)'(0)}));
        return sum[FRAC_BITS+7:FRAC_BITS];
    endfunction

    assign pop = in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lut_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            lut_valid_reg <= in_valid;
            done_reg      <= lut_valid_reg;
        end
    end

    // end entry of the palette pairs with a padding entry; its weight is zero
    always_ff @(posedge clk)
    begin
        lo_reg    <= pal_color(pal, seg);
        hi_reg    <= pal_color(pal, seg + 1'b1);
        frac_reg  <= frac;
        color_reg <= color_next;
    end

    always_comb
    begin
        color_next.r = blend(lo_reg.r, hi_reg.r, frac_reg);
        color_next.g = blend(lo_reg.g, hi_reg.g, frac_reg);
        color_next.b = blend(lo_reg.b, hi_reg.b, frac_reg);
    end

    assign done  = done_reg;
    assign red   = color_reg.r;
    assign green = color_reg.g;
    assign blue  = color_reg.b;

endmodule

// File: sim/colormap_interpolator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_interpolator_checker
// Watches the level, colour and palette channels of the colormap interpolator.
// Keeps its own palette register and works out each expected colour by linear
// blending between palette entries, rounded half up. Each strobed colour is
// compared field by field with the oldest expected colour.
// ----------------------------------------------------------------------------
module colormap_interpolator_checker
    import cmi_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [FRAC_BITS:0] level,
    input  logic               done,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [PAL_W-1:0]   cfg_data,
    output int unsigned        errors,
    output int unsigned        outstanding,
    output int unsigned        checked
);

    localparam longint unsigned ONE       = 64'd1 << FRAC_BITS;
    localparam int              DIV_KNOTS = 11;
    localparam int              SEQ_KNOTS = 9;

    // own copy of the five palettes, unused tail entries left at zero
    localparam logic [23:0] SWATCH [5][DIV_KNOTS] = '{
        '{24'h67001f, 24'hb2182b, 24'hd6604d, 24'hf4a582, 24'hfddbc7, 24'hf7f7f7,
          24'hd1e5f0, 24'h92c5de, 24'h4393c3, 24'h2166ac, 24'h053061},
        '{24'hffffe5, 24'hfff7bc, 24'hfee391, 24'hfec44f, 24'hfe9929, 24'hec7014,
          24'hcc4c02, 24'h993404, 24'h662506, 24'h000000, 24'h000000},
        '{24'hf7fbff, 24'hdeebf7, 24'hc6dbef, 24'h9ecae1, 24'h6baed6, 24'h4292c6,
          24'h2171b5, 24'h08519c, 24'h08306b, 24'h000000, 24'h000000},
        '{24'hfff5f0, 24'hfee0d2, 24'hfcbba1, 24'hfc9272, 24'hfb6a4a, 24'hef3b2c,
          24'hcb181d, 24'ha50f15, 24'h67000d, 24'h000000, 24'h000000},
        '{24'hf7fcf5, 24'he5f5e0, 24'hc7e9c0, 24'ha1d99b, 24'h74c476, 24'h41ab5d,
          24'h238b45, 24'h006d2c, 24'h00441b, 24'h000000, 24'h000000}
    };

    logic [PAL_W-1:0] pal_sel = PAL_DIVERGING;
    rgb_t             colour_q [$];
    int unsigned      err_cnt = 0;
    int unsigned      chk_cnt = 0;

    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                       input longint unsigned frac);
        longint unsigned num;
        num = longint'(a) * (ONE - frac) + longint'(b) * frac + (ONE >> 1);
        return 8'(num >> FRAC_BITS);
    endfunction

    function automatic rgb_t blend_colour(input logic [PAL_W-1:0] code,
                                          input logic [FRAC_BITS:0] lvl);
        int              row;
        int              last;
        int              seg;
        longint unsigned scaled;
        longint unsigned frac;
        logic [23:0]     lo;
        logic [23:0]     hi;
        rgb_t            c;
        case (code)
            PAL_YLORBR: row = 1;
            PAL_BLUES:  row = 2;
            PAL_REDS:   row = 3;
            PAL_GREENS: row = 4;
            default:    row = 0;
        endcase
        last = (row == 0) ? DIV_KNOTS - 1 : SEQ_KNOTS - 1;
        if (lvl == '0) begin
            c = rgb_t'(SWATCH[row][0]);
        end
        else if (longint'(lvl) >= ONE) begin
            c = rgb_t'(SWATCH[row][last]);
        end
        else begin
            scaled = longint'(lvl) * longint'(last);
            seg    = int'(scaled >> FRAC_BITS);
            frac   = scaled & (ONE - 1);
            if (seg > last - 1)
                seg = last - 1;
            lo  = SWATCH[row][seg];
            hi  = SWATCH[row][seg + 1];
            c.r = mix(lo[23:16], hi[23:16], frac);
            c.g = mix(lo[15:8], hi[15:8], frac);
            c.b = mix(lo[7:0], hi[7:0], frac);
        end
        return c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t want;
        if (!rst_n) begin
            pal_sel <= PAL_DIVERGING;
            colour_q.delete();
            outstanding <= 0;
        end
        else begin
            if (done) begin
                if (colour_q.size() == 0) begin
                    $error("colour strobe with no item outstanding");
                    err_cnt++;
                end
                else begin
                    want = colour_q.pop_front();
                    chk_cnt++;
                    if (red !== want.r) begin
                        $error("red mismatch: expected %0h, actual %0h", want.r, red);
                        err_cnt++;
                    end
                    if (green !== want.g) begin
                        $error("green mismatch: expected %0h, actual %0h", want.g, green);
                        err_cnt++;
                    end
                    if (blue !== want.b) begin
                        $error("blue mismatch: expected %0h, actual %0h", want.b, blue);
                        err_cnt++;
                    end
                end
            end
            if (start && !busy)
                colour_q.push_back(blend_colour(pal_sel, level));
            if (cfg_valid && cfg_ready)
                pal_sel <= cfg_data;
            outstanding <= colour_q.size();
        end
        errors  <= err_cnt;
        checked <= chk_cnt;
    end

endmodule

// File: sim/colormap_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_interpolator_tb
// Drives levels and palette writes into the colormap interpolator: corner
// levels first, then random phases over every palette code with random gaps,
// back-to-back bursts and a full drain. A checker beside the block predicts
// and compares every colour; this module gives the verdict.
// ----------------------------------------------------------------------------
module colormap_interpolator_tb;
    import cmi_pkg::*;

    localparam int FRAC_BITS  = 16;
    localparam int LEVEL_ONE  = 1 << FRAC_BITS;
    localparam int LEVEL_MAX  = (2 << FRAC_BITS) - 1;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 164;
    localparam int IDLE_LIMIT = 2000;

    // codes past the last palette
    localparam logic [PAL_W-1:0] PAL_UNUSED_LO  = PAL_COUNT;
    localparam logic [PAL_W-1:0] PAL_UNUSED_MID = 3'd6;
    localparam logic [PAL_W-1:0] PAL_UNUSED_HI  = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [FRAC_BITS:0] level = '0;
    logic               done;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [PAL_W-1:0]   cfg_data = PAL_DIVERGING;

    int unsigned errors;
    int unsigned outstanding;
    int unsigned checked;
    int unsigned sent = 0;
    int unsigned idle = 0;

    int unsigned      corner_levels [$];
    logic [PAL_W-1:0] phase_codes [$];

    colormap_interpolator #(
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .level     (level),
        .done      (done),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    colormap_interpolator_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_colour_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .level       (level),
        .done        (done),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [FRAC_BITS:0] pick_level();
        int kind;
        int v;
        kind = $urandom_range(0, 99);
        if (kind < 50)
            v = $urandom_range(0, LEVEL_ONE);
        else if (kind < 65)
            v = $urandom_range(0, 8) * (LEVEL_ONE / 8) + $urandom_range(0, 2) - 1;
        else if (kind < 75)
            v = LEVEL_ONE * $urandom_range(0, 1) + $urandom_range(0, 2) - 1;
        else if (kind < 90)
            v = $urandom_range(LEVEL_ONE + 1, LEVEL_MAX);
        else
            v = $urandom();
        return v[FRAC_BITS:0];
    endfunction

    task automatic send_level(input logic [FRAC_BITS:0] lvl, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        level <= lvl;
        do @(posedge clk); while (busy);
        sent++;
    endtask

    // hold off until every colour in flight has come back
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_palette(input logic [PAL_W-1:0] code);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // watchdog on cycles with no handshake of any kind
    initial
    begin
        while (idle < IDLE_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        bit burst;
        corner_levels = '{0, 1, LEVEL_ONE / 2 - 1, LEVEL_ONE / 2, LEVEL_ONE / 2 + 1,
                          LEVEL_ONE / 8, 3 * LEVEL_ONE / 8, LEVEL_ONE - 1, LEVEL_ONE,
                          LEVEL_ONE + 1, LEVEL_ONE + LEVEL_ONE / 2, LEVEL_MAX,
                          LEVEL_MAX / 3, 2 * LEVEL_MAX / 3};
        phase_codes   = '{PAL_YLORBR, PAL_BLUES, PAL_REDS, PAL_GREENS, PAL_UNUSED_LO,
                          PAL_UNUSED_MID, PAL_UNUSED_HI, PAL_DIVERGING, PAL_GREENS,
                          PAL_YLORBR};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner levels under the reset palette
        foreach (corner_levels[i])
            send_level(corner_levels[i][FRAC_BITS:0], 0);

        for (int p = 0; p < PHASES; p++) begin
            write_palette(phase_codes[p]);
            burst = (p == 0) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_LEN; i++) begin
                if (p == 3 && i == PHASE_LEN / 2)
                    drain();
                send_level(pick_level(), burst ? 0 : $urandom_range(0, 4));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        $display("Drove %0d levels through palette codes 0 to 7, %0d colours checked.",
                 sent, checked);
        $display("Covered floor, ceiling, knots, above-one levels, gaps and bursts.");
        if (errors == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
